### src/tld_pkg.sv
// Shared types, sizes and character codes for the terminal line discipline.
// No dependencies; every other file of the block imports this package.
package tld_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int LINE_DEPTH = 256;
  localparam int BYTE_W     = 8;

  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int LINE_LW = $clog2(LINE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_ETX = 8'd3;
  localparam logic [BYTE_W-1:0] CH_EOT = 8'd4;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SUB = 8'd26;
  localparam logic [BYTE_W-1:0] CH_ESC = 8'd27;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_RAW_MODE = 1'b0;
  localparam logic REG_ECHO     = 1'b1;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_SUSP = 2'd2;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_READ = 2'd1,
    KIND_PUSH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NODATA = 2'd1,
    ST_EOF    = 2'd2
  } status_t;

  // All results caused by one item: up to three echo bytes, then one reply.
  typedef struct packed {
    logic [1:0]                  echo_cnt;
    logic [2:0][BYTE_W-1:0]      echo_byte;
    kind_t                       kind;
    logic [BYTE_W-1:0]           data;
    status_t                     status;
    logic                        acc;
    logic                        avail;
  } bundle_t;

  function automatic logic is_term(input logic [BYTE_W-1:0] b);
    return (b == CH_LF) || (b == CH_CR) || (b == CH_EOT);
  endfunction

endpackage

### src/tty_line_discipline.sv
// Terminal input line discipline. An accepted item waits in the item register,
// is executed in one pass and its results go to the result register. A push
// gives one result, a read up to four (echo bytes, reply), sent one per cycle
// unless stalled, so pushes run at one item per cycle and a read holds the
// next item until its last result is taken. Reset selects cooked mode with
// echo on and clears pointers, counts and flags; stores are kept.
module tty_line_discipline import tld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        kind,
  output logic [BYTE_W-1:0] data_byte,
  output logic [1:0]        read_status,
  output logic              accepted,
  output logic              line_available,
  output logic              last
);

  logic               raw_mode;
  logic               echo_enable;
  logic [FIFO_AW-1:0] head, head_next;
  logic [FIFO_AW-1:0] tail, tail_next;
  logic [FIFO_CW-1:0] count, count_next;
  logic [FIFO_CW-1:0] term_cnt, term_cnt_next;
  logic [LINE_LW-1:0] line_len, line_len_next;
  logic [LINE_LW-1:0] read_pos, read_pos_next;
  logic               line_ready, line_ready_next;
  logic [1:0]         sig_pend, sig_pend_next;

  logic               pend_valid;
  logic               pend_opcode;
  logic [BYTE_W-1:0]  pend_byte;

  logic               seq_free;
  logic               exec_go;
  logic               item_xfer;
  bundle_t            bnd;

  logic               fifo_we;
  logic [BYTE_W-1:0]  fifo_rd;
  logic               line_we;
  logic [BYTE_W-1:0]  line_wdata;
  logic [BYTE_W-1:0]  line_rd;
  logic [LINE_LW-1:0] eff_len;
  logic [LINE_LW-1:0] new_len;
  logic [LINE_LW-1:0] pos_inc;
  logic               do_pop;

  assign exec_go    = pend_valid && seq_free;
  assign item_stall = pend_valid && !seq_free;
  assign item_xfer  = item_valid && !item_stall;
  // A line that was being drained counts as empty once it is used up.
  assign eff_len    = line_ready ? '0 : line_len;
  assign pos_inc    = read_pos + LINE_LW'(1);

  tld_ram #(.DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (tail),
    .wr_data (pend_byte),
    .rd_addr (head_next),
    .rd_data (fifo_rd)
  );

  tld_ram #(.DEPTH(LINE_DEPTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (eff_len[LINE_AW-1:0]),
    .wr_data (line_wdata),
    .rd_addr (read_pos_next[LINE_AW-1:0]),
    .rd_data (line_rd)
  );

  // The RAM read ports follow the next head and read position, so fifo_rd
  // always holds the head byte and line_rd the byte at the read position.
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    term_cnt_next   = term_cnt;
    line_len_next   = line_len;
    read_pos_next   = read_pos;
    line_ready_next = line_ready;
    sig_pend_next   = sig_pend;
    fifo_we         = 1'b0;
    line_we         = 1'b0;
    line_wdata      = fifo_rd;
    new_len         = eff_len;
    do_pop          = 1'b0;
    bnd             = '0;
    bnd.kind        = KIND_READ;
    bnd.status      = ST_NODATA;
    bnd.echo_byte   = {CH_BS, CH_SP, CH_BS};

    if (exec_go) begin
      if (pend_opcode == OP_PUSH) begin
        bnd.kind   = KIND_PUSH;
        bnd.status = ST_OK;
        if (!raw_mode && (pend_byte == CH_ETX)) begin
          sig_pend_next = SIG_INTR;
          bnd.acc       = 1'b1;
        end else if (!raw_mode && (pend_byte == CH_SUB)) begin
          sig_pend_next = SIG_SUSP;
          bnd.acc       = 1'b1;
        end else if (count != FIFO_CW'(FIFO_DEPTH)) begin
          fifo_we    = 1'b1;
          tail_next  = (tail == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail + FIFO_AW'(1);
          count_next = count + FIFO_CW'(1);
          if (is_term(pend_byte)) begin
            term_cnt_next = term_cnt + FIFO_CW'(1);
          end
          bnd.acc = 1'b1;
        end
      end else if ((sig_pend == SIG_INTR) || (sig_pend == SIG_SUSP)) begin
        sig_pend_next = SIG_NONE;
        bnd.status    = ST_OK;
        bnd.data      = (sig_pend == SIG_INTR) ? CH_ETX : CH_SUB;
      end else begin
        sig_pend_next = SIG_NONE;
        if (raw_mode) begin
          if (count != '0) begin
            do_pop     = 1'b1;
            bnd.status = ST_OK;
            bnd.data   = fifo_rd;
          end
        end else if (line_ready && (read_pos < line_len)) begin
          bnd.status = ST_OK;
          bnd.data   = line_rd;
          if (pos_inc >= line_len) begin
            line_len_next   = '0;
            read_pos_next   = '0;
            line_ready_next = 1'b0;
          end else begin
            read_pos_next = pos_inc;
          end
        end else begin
          line_ready_next = 1'b0;
          line_len_next   = eff_len;
          read_pos_next   = '0;
          if (count != '0) begin
            do_pop = 1'b1;
            if ((fifo_rd == CH_BS) || (fifo_rd == CH_DEL)) begin
              if (eff_len != '0) begin
                line_len_next = eff_len - LINE_LW'(1);
                bnd.echo_cnt  = 2'd3;
              end
            end else if (is_term(fifo_rd)) begin
              if ((fifo_rd == CH_EOT) && (eff_len == '0)) begin
                bnd.status = ST_EOF;
              end else begin
                if (fifo_rd != CH_EOT) begin
                  if (eff_len != LINE_LW'(LINE_DEPTH)) begin
                    line_we = 1'b1;
                    new_len = eff_len + LINE_LW'(1);
                  end
                  bnd.echo_cnt  = 2'd2;
                  bnd.echo_byte = {CH_BS, CH_LF, CH_CR};
                end
                // The finishing read returns the first byte of the line.
                bnd.status = ST_OK;
                bnd.data   = (eff_len == '0) ? fifo_rd : line_rd;
                if (new_len <= LINE_LW'(1)) begin
                  line_len_next   = '0;
                  read_pos_next   = '0;
                  line_ready_next = 1'b0;
                end else begin
                  line_len_next   = new_len;
                  read_pos_next   = LINE_LW'(1);
                  line_ready_next = 1'b1;
                end
              end
            end else if ((fifo_rd != CH_ESC) && (eff_len != LINE_LW'(LINE_DEPTH))) begin
              line_we       = 1'b1;
              line_len_next = eff_len + LINE_LW'(1);
              bnd.echo_cnt  = 2'd1;
              bnd.echo_byte = {CH_BS, CH_SP, fifo_rd};
            end
          end
        end
      end

      if (do_pop) begin
        head_next  = (head == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head + FIFO_AW'(1);
        count_next = count - FIFO_CW'(1);
        if (is_term(fifo_rd) && (term_cnt != '0)) begin
          term_cnt_next = term_cnt - FIFO_CW'(1);
        end
      end
    end

    if (!echo_enable) begin
      bnd.echo_cnt = '0;
    end
    if (raw_mode) begin
      bnd.avail = (count_next != '0);
    end else begin
      bnd.avail = (line_ready_next && (read_pos_next < line_len_next)) ||
                  (term_cnt_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode    <= 1'b0;
      echo_enable <= 1'b1;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      term_cnt    <= '0;
      line_len    <= '0;
      read_pos    <= '0;
      line_ready  <= 1'b0;
      sig_pend    <= SIG_NONE;
      pend_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_MODE: raw_mode    <= cfg_data;
          REG_ECHO:     echo_enable <= cfg_data;
          default:      ;
        endcase
      end
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      term_cnt   <= term_cnt_next;
      line_len   <= line_len_next;
      read_pos   <= read_pos_next;
      line_ready <= line_ready_next;
      sig_pend   <= sig_pend_next;
      if (item_xfer) begin
        pend_valid <= 1'b1;
      end else if (exec_go) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      pend_opcode <= opcode;
      pend_byte   <= byte_in;
    end
  end

  tld_out_seq u_out_seq (
    .clk            (clk),
    .rst            (rst),
    .load           (exec_go),
    .bundle_in      (bnd),
    .free           (seq_free),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .read_status    (read_status),
    .accepted       (accepted),
    .line_available (line_available),
    .last           (last)
  );

endmodule

### src/tld_ram.sv
// Simple dual-port byte memory with registered read and write-to-read bypass.
// Depends on tld_pkg for the byte width.
module tld_ram import tld_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // A byte written at the address being read shows up on the next cycle.
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/tld_out_seq.sv
// Result register that hands out the results of one item, one per transfer.
// Depends on tld_pkg for the bundle type.
module tld_out_seq import tld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bundle_t           bundle_in,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        kind,
  output logic [BYTE_W-1:0] data_byte,
  output logic [1:0]        read_status,
  output logic              accepted,
  output logic              line_available,
  output logic              last
);

  bundle_t    bnd;
  logic [1:0] idx;
  logic       busy;
  logic       on_reply;
  logic       xfer;

  assign on_reply     = (idx == bnd.echo_cnt);
  assign xfer         = busy && !result_stall;
  assign free         = !busy || (xfer && on_reply);
  assign result_valid = busy;
  assign last         = on_reply;
  assign line_available = bnd.avail;

  always_comb begin
    kind        = KIND_ECHO;
    data_byte   = '0;
    read_status = ST_OK;
    accepted    = 1'b0;
    if (on_reply) begin
      kind        = bnd.kind;
      data_byte   = bnd.data;
      read_status = bnd.status;
      accepted    = bnd.acc;
    end else begin
      case (idx)
        2'd0:    data_byte = bnd.echo_byte[0];
        2'd1:    data_byte = bnd.echo_byte[1];
        default: data_byte = bnd.echo_byte[2];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (on_reply) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd <= bundle_in;
    end
  end

endmodule
